/* hdl/kelly_lochbaum_tube_filter_top_defines.svh */
// Assertion helpers for the lattice filter controller.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KELLY_LOCHBAUM_TUBE_FILTER_TOP_DEFINES_SVH
`define KELLY_LOCHBAUM_TUBE_FILTER_TOP_DEFINES_SVH

// The condition implies the property in the same cycle.
`define KLT_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("klt: same-cycle check failed");

// The condition implies the property in the next cycle.
`define KLT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("klt: next-cycle check failed");

`endif

/* hdl/klt_pkg.sv */
package klt_pkg;

    localparam int FUNC_W = 2;
    localparam int SMP_W  = 24;
    localparam int GAIN_W = 16;
    localparam int NJ_W   = 5;
    localparam int RAD_W  = 16;
    localparam int K_W    = 18;
    localparam int X_W    = 44;
    localparam int Y_W    = 19;
    localparam int P_W    = X_W + Y_W;
    localparam int SQ_W   = 2 * RAD_W;
    localparam int DEN_W  = SQ_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int DIV_STEPS = 17;
    localparam int DCNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RADIUS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [RAD_W-1:0] RAD_ONE = 16'd256;
    localparam logic signed [Y_W-1:0] ONE_Q16 = 19'sd65536;
    localparam logic [NJ_W-1:0] NJ_RESET = 5'd16;

    typedef enum logic [1:0] {
        SC_FWD  = 2'd0,
        SC_BWD  = 2'd1,
        SC_LAST = 2'd2
    } sc_kind_t;

    typedef enum logic [2:0] {
        MS_A_GA    = 3'd0,
        MS_B_GB    = 3'd1,
        MS_ACC_DMP = 3'd2,
        MS_SQ_A    = 3'd3,
        MS_SQ_B    = 3'd4
    } mul_src_t;

    typedef struct packed {
        logic     sweep_we;
        logic     sweep_init;
        logic     ld_sample;
        logic     ld_radius;
        logic     lat_wave;
        logic     mul_en;
        mul_src_t mul_src;
        sc_kind_t kind;
        logic     acc_load;
        logic     acc_add;
        logic     wr_fn;
        logic     wr_fn_x;
        logic     wr_bf;
        logic     step;
        logic     out_load;
        logic     rad_wr;
        logic     rad_side;
        logic     rad_lat;
        logic     sq_lat;
        logic     div_init;
        logic     div_step;
        logic     k_wr;
    } klt_cmd_t;

    typedef struct packed {
        logic out_full;
        logic idx_zero;
        logic idx_top;
    } klt_status_t;

    // Round half up after a right shift by 30, then saturate to 24 bits.
    function automatic logic signed [SMP_W-1:0] sat_round30(input logic signed [P_W-1:0] p);
        logic signed [P_W:0]  t;
        logic signed [P_W-30:0] s;
        t = (P_W+1)'(p) + (P_W+1)'(64'sd536870912);
        s = t[P_W:30];
        if (s > (P_W-29)'(64'sd8388607)) begin
            return 24'sh7FFFFF;
        end else if (s < (P_W-29)'(-64'sd8388608)) begin
            return 24'sh800000;
        end
        return s[SMP_W-1:0];
    endfunction

endpackage

/* hdl/kelly_lochbaum_tube_filter_top.sv */
// Kelly-Lochbaum tube lattice filter. After reset the block runs a clearing
// pass over addresses 0 to MAX_JUNCTIONS (wave stores and coefficients to zero,
// section radii to 1.0) and holds in_ready low meanwhile. For a sample request,
// every junction term is formed on one shared multiplier in five steps, and each
// junction needs one read of its wave and coefficient memories. A radius request
// recomputes up to two coefficients, mostly in a 17-step restoring divider. A
// clear request sweeps the wave memories. The result register lets a new request
// start while the previous sample waits on out_ready. feedback_gain is not
// connected to the datapath, so it has no effect on the output.
module kelly_lochbaum_tube_filter_top import klt_pkg::*; #(
    parameter int MAX_JUNCTIONS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [NJ_W-1:0]          cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [SMP_W-1:0]  sample_in,
    input  logic signed [GAIN_W-1:0] feedback_gain,
    input  logic signed [GAIN_W-1:0] damping,
    input  logic [NJ_W-1:0]          tube_index,
    input  logic [RAD_W-1:0]         radius,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SMP_W-1:0]  sample_out
);

    localparam int JW = $clog2(MAX_JUNCTIONS);
    localparam int RW = $clog2(MAX_JUNCTIONS + 1);

    klt_cmd_t    cmd;
    klt_status_t status;
    logic [JW-1:0] j;
    logic [RW-1:0] sweep_addr;
    logic [RW-1:0] nj;

    klt_ctrl #(.MAX_JUNCTIONS(MAX_JUNCTIONS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd),
        .j           (j),
        .sweep_addr  (sweep_addr),
        .nj          (nj)
    );

    klt_dp #(.MAX_JUNCTIONS(MAX_JUNCTIONS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .j          (j),
        .sweep_addr (sweep_addr),
        .nj         (nj),
        .sample_in  (sample_in),
        .damping    (damping),
        .tube_index (tube_index),
        .radius     (radius),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule

/* hdl/klt_ram.sv */
module klt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/klt_dp.sv */
module klt_dp import klt_pkg::*; #(
    parameter int MAX_JUNCTIONS = 16,
    localparam int JW = $clog2(MAX_JUNCTIONS),
    localparam int RW = $clog2(MAX_JUNCTIONS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  klt_cmd_t                 cmd,
    output klt_status_t              status,
    input  logic [JW-1:0]            j,
    input  logic [RW-1:0]            sweep_addr,
    input  logic [RW-1:0]            nj,
    input  logic signed [SMP_W-1:0]  sample_in,
    input  logic signed [GAIN_W-1:0] damping,
    input  logic [NJ_W-1:0]          tube_index,
    input  logic [RAD_W-1:0]         radius,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [SMP_W-1:0]  sample_out
);

    localparam int CW = (RW > NJ_W) ? RW : NJ_W;

    // Sample registers and per-junction carries.
    logic signed [SMP_W-1:0] xin_reg, ffp_reg, fnprev_reg, bfj_reg, fncur_reg, bfn_reg, ffc_reg;
    logic signed [GAIN_W-1:0] dmp_reg;
    logic signed [K_W-1:0] kprev_reg, kcur_reg;
    logic signed [X_W-1:0] acc_reg;
    logic signed [P_W-1:0] prod_reg;

    // Radius and division registers.
    logic [RW-1:0]    idx_reg;
    logic [RAD_W-1:0] rad_reg, other_reg;
    logic [SQ_W-1:0]  a2_reg;
    logic [DEN_W-1:0] den_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic neg_reg, dz_reg;

    logic out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0] sample_out_reg;

    logic [SMP_W-1:0] fn_rdata, bf_rdata;
    logic [K_W-1:0]   k_rdata;
    logic [RAD_W-1:0] rad_rdata;

    logic sweep_in_range;
    logic fn_we, bf_we, k_we, rad_we;
    logic [JW-1:0] wave_waddr, k_waddr, c_idx, bf_raddr;
    logic [RW-1:0] rad_waddr, rad_raddr;
    logic [SMP_W-1:0] fn_wdata, bf_wdata;
    logic [K_W-1:0] k_wdata;
    logic [RAD_W-1:0] rad_wdata;

    logic signed [SMP_W-1:0] res, sa, sb;
    logic signed [Y_W-1:0] ga, gb, kp19, kc19;
    logic signed [X_W-1:0] mx;
    logic signed [Y_W-1:0] my;
    logic [RAD_W-1:0] ra, rb;
    logic [RW-1:0] idx_clamped;

    logic [SQ_W-1:0]  b2;
    logic [DEN_W-1:0] den_w;
    logic [SQ_W-1:0]  num_w;
    logic [SQ_W+17-1:0] dvd_w;
    logic [REM_W-1:0] remx;
    logic ge;
    logic [K_W-1:0] kmag, kval;

    assign res = sat_round30(prod_reg);
    assign sweep_in_range = (sweep_addr < RW'(MAX_JUNCTIONS));

    // Wave, coefficient and radius stores.
    assign wave_waddr = cmd.sweep_we ? sweep_addr[JW-1:0] : j;
    assign fn_we    = (cmd.sweep_we && sweep_in_range) || cmd.wr_fn || cmd.wr_fn_x;
    assign fn_wdata = cmd.sweep_we ? '0 : (cmd.wr_fn_x ? xin_reg : res);
    assign bf_we    = (cmd.sweep_we && sweep_in_range) || cmd.wr_bf;
    assign bf_wdata = cmd.sweep_we ? '0 : res;
    assign bf_raddr = JW'(j + JW'(1));

    assign c_idx   = cmd.rad_side ? idx_reg[JW-1:0] : JW'(idx_reg - RW'(1));
    assign k_we    = (cmd.sweep_we && cmd.sweep_init && sweep_in_range) || cmd.k_wr;
    assign k_waddr = cmd.sweep_we ? sweep_addr[JW-1:0] : c_idx;
    assign k_wdata = cmd.sweep_we ? '0 : kval;

    assign rad_we    = (cmd.sweep_we && cmd.sweep_init) || cmd.rad_wr;
    assign rad_waddr = cmd.sweep_we ? sweep_addr : idx_reg;
    assign rad_wdata = cmd.sweep_we ? RAD_ONE : rad_reg;
    assign rad_raddr = cmd.rad_side ? RW'(idx_reg + RW'(1)) : RW'(idx_reg - RW'(1));

    klt_ram #(.WIDTH(SMP_W), .DEPTH(MAX_JUNCTIONS)) u_fn_ram (
        .clk(clk), .we(fn_we), .waddr(wave_waddr), .wdata(fn_wdata),
        .raddr(j), .rdata(fn_rdata)
    );

    klt_ram #(.WIDTH(SMP_W), .DEPTH(MAX_JUNCTIONS)) u_bf_ram (
        .clk(clk), .we(bf_we), .waddr(wave_waddr), .wdata(bf_wdata),
        .raddr(bf_raddr), .rdata(bf_rdata)
    );

    klt_ram #(.WIDTH(K_W), .DEPTH(MAX_JUNCTIONS)) u_k_ram (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(j), .rdata(k_rdata)
    );

    klt_ram #(.WIDTH(RAD_W), .DEPTH(MAX_JUNCTIONS + 1)) u_rad_ram (
        .clk(clk), .we(rad_we), .waddr(rad_waddr), .wdata(rad_wdata),
        .raddr(rad_raddr), .rdata(rad_rdata)
    );

    // Scatter operands for the three junction terms.
    assign kp19 = Y_W'(kprev_reg);
    assign kc19 = Y_W'(kcur_reg);

    always_comb
    begin
        unique case (cmd.kind)
            SC_FWD:
            begin
                sa = ffp_reg;  ga = ONE_Q16 - kp19;
                sb = bfj_reg;  gb = -kp19;
            end
            SC_BWD:
            begin
                sa = bfn_reg;  ga = ONE_Q16 + kc19;
                sb = ffc_reg;  gb = kc19;
            end
            SC_LAST:
            begin
                sa = ffp_reg;  ga = ONE_Q16 - kc19;
                sb = '0;       gb = '0;
            end
            default:
            begin
                sa = '0;       ga = '0;
                sb = '0;       gb = '0;
            end
        endcase
    end

    assign ra = cmd.rad_side ? rad_reg : other_reg;
    assign rb = cmd.rad_side ? other_reg : rad_reg;

    always_comb
    begin
        unique case (cmd.mul_src)
            MS_A_GA:    begin mx = X_W'(sa);                 my = ga; end
            MS_B_GB:    begin mx = X_W'(sb);                 my = gb; end
            MS_ACC_DMP: begin mx = acc_reg;                  my = Y_W'(dmp_reg); end
            MS_SQ_A:    begin mx = $signed(X_W'(ra));        my = $signed(Y_W'(ra)); end
            MS_SQ_B:    begin mx = $signed(X_W'(rb));        my = $signed(Y_W'(rb)); end
            default:    begin mx = '0;                       my = '0; end
        endcase
    end

    // Reflection coefficient: round((a2 - b2) * 2^16 / (a2 + b2)) by restoring division.
    assign b2    = prod_reg[SQ_W-1:0];
    assign den_w = DEN_W'(a2_reg) + DEN_W'(b2);
    assign num_w = (a2_reg >= b2) ? (a2_reg - b2) : (b2 - a2_reg);
    assign dvd_w = {num_w, 16'b0} + (SQ_W+17)'(den_w >> 1);
    assign remx  = {rem_reg[REM_W-2:0], dq_reg[DIV_STEPS-1]};
    assign ge    = (remx >= REM_W'(den_reg));
    assign kmag  = K_W'(dq_reg);
    assign kval  = dz_reg ? '0 : (neg_reg ? K_W'(-kmag) : kmag);

    assign idx_clamped = (CW'(tube_index) > CW'(nj)) ? nj : RW'(tube_index);

    always_ff @(posedge clk)
    begin
        if (cmd.ld_sample)
        begin
            xin_reg <= sample_in;
            dmp_reg <= damping;
        end
        if (cmd.lat_wave)
        begin
            fncur_reg <= $signed(fn_rdata);
            bfn_reg   <= $signed(bf_rdata);
            kcur_reg  <= $signed(k_rdata);
            ffc_reg   <= (j == '0) ? xin_reg : fnprev_reg;
        end
        if (cmd.step)
        begin
            fnprev_reg <= fncur_reg;
            ffp_reg    <= ffc_reg;
            bfj_reg    <= bfn_reg;
            kprev_reg  <= kcur_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mx * my;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= $signed(prod_reg[X_W-1:0]);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + $signed(prod_reg[X_W-1:0]);
        end
        if (cmd.ld_radius)
        begin
            idx_reg <= idx_clamped;
            rad_reg <= radius;
        end
        if (cmd.rad_lat)
        begin
            other_reg <= rad_rdata;
        end
        if (cmd.sq_lat)
        begin
            a2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.div_init)
        begin
            den_reg <= den_w;
            neg_reg <= (a2_reg < b2);
            dz_reg  <= (den_w == '0);
            rem_reg <= REM_W'(dvd_w[SQ_W+16:17]);
            dq_reg  <= dvd_w[DIV_STEPS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? (remx - REM_W'(den_reg)) : remx;
            dq_reg  <= {dq_reg[DIV_STEPS-2:0], ge};
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= res;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign status.out_full = out_valid_reg;
    assign status.idx_zero = (idx_reg == '0);
    assign status.idx_top  = (idx_reg == RW'(MAX_JUNCTIONS));

endmodule

/* hdl/klt_ctrl.sv */
`include "kelly_lochbaum_tube_filter_top_defines.svh"

module klt_ctrl import klt_pkg::*; #(
    parameter int MAX_JUNCTIONS = 16,
    localparam int JW = $clog2(MAX_JUNCTIONS),
    localparam int RW = $clog2(MAX_JUNCTIONS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [NJ_W-1:0]   cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic              out_ready,
    input  klt_status_t       status,
    output klt_cmd_t          cmd,
    output logic [JW-1:0]     j,
    output logic [RW-1:0]     sweep_addr,
    output logic [RW-1:0]     nj
);

    localparam int CW = (RW > NJ_W) ? RW : NJ_W;

    typedef enum logic [17:0] {
        ST_SWEEP   = 18'b000000000000000001,
        ST_IDLE    = 18'b000000000000000010,
        ST_P_RD    = 18'b000000000000000100,
        ST_P_LAT   = 18'b000000000000001000,
        ST_P_WRX   = 18'b000000000000010000,
        ST_M1      = 18'b000000000000100000,
        ST_M2      = 18'b000000000001000000,
        ST_ACC     = 18'b000000000010000000,
        ST_M3      = 18'b000000000100000000,
        ST_WR      = 18'b000000001000000000,
        ST_R_WR    = 18'b000000010000000000,
        ST_R_RD    = 18'b000000100000000000,
        ST_R_LAT   = 18'b000001000000000000,
        ST_R_SQA   = 18'b000010000000000000,
        ST_R_SQB   = 18'b000100000000000000,
        ST_R_DINIT = 18'b001000000000000000,
        ST_R_DIV   = 18'b010000000000000000,
        ST_R_KWR   = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;
    logic [RW-1:0] sweep_reg, sweep_next;
    logic init_reg, init_next;
    sc_kind_t kind_reg, kind_next;
    logic side_reg, side_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [NJ_W-1:0] njcfg_reg, njcfg_next;

    logic [CW-1:0] njc;
    logic [RW-1:0] nj_eff;
    logic [RW-1:0] sweep_last;
    logic j_last;
    logic out_free;
    logic in_accept;
    logic sample_busy;

    // Active junctions, held to the range the lattice supports.
    assign njc = CW'(njcfg_reg);
    always_comb
    begin
        priority if (njc < CW'(2))
        begin
            nj_eff = RW'(2);
        end
        else if (njc > CW'(MAX_JUNCTIONS))
        begin
            nj_eff = RW'(MAX_JUNCTIONS);
        end
        else
        begin
            nj_eff = RW'(njc);
        end
    end

    assign nj         = nj_eff;
    assign j          = j_reg;
    assign sweep_addr = sweep_reg;
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign j_last     = ((RW'(j_reg) + RW'(1)) == nj_eff);
    assign out_free   = !status.out_full || out_ready;
    assign sweep_last = init_reg ? RW'(MAX_JUNCTIONS) : RW'(MAX_JUNCTIONS - 1);
    assign njcfg_next = cfg_wr_en ? cfg_wr_data : njcfg_reg;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        sweep_next = sweep_reg;
        init_next  = init_reg;
        kind_next  = kind_reg;
        side_next  = side_reg;
        dcnt_next  = dcnt_reg;
        cmd          = '0;
        cmd.kind     = kind_reg;
        cmd.mul_src  = MS_A_GA;
        cmd.rad_side = side_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_we   = 1'b1;
                cmd.sweep_init = init_reg;
                if (sweep_reg == sweep_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = RW'(sweep_reg + RW'(1));
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_SAMPLE:
                        begin
                            cmd.ld_sample = 1'b1;
                            j_next        = '0;
                            state_next    = ST_P_RD;
                        end
                        FUNC_RADIUS:
                        begin
                            cmd.ld_radius = 1'b1;
                            state_next    = ST_R_WR;
                        end
                        FUNC_CLEAR:
                        begin
                            sweep_next = '0;
                            init_next  = 1'b0;
                            state_next = ST_SWEEP;
                        end
                        FUNC_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_P_RD:
            begin
                state_next = ST_P_LAT;
            end
            ST_P_LAT:
            begin
                cmd.lat_wave = 1'b1;
                priority if (j_reg == '0)
                begin
                    state_next = ST_P_WRX;
                end
                else if (j_last)
                begin
                    kind_next  = SC_LAST;
                    state_next = ST_M1;
                end
                else
                begin
                    kind_next  = SC_FWD;
                    state_next = ST_M1;
                end
            end
            ST_P_WRX:
            begin
                // The first junction passes the excitation straight through.
                cmd.wr_fn_x = 1'b1;
                kind_next   = SC_BWD;
                state_next  = ST_M1;
            end
            ST_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_A_GA;
                state_next  = ST_M2;
            end
            ST_M2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = MS_B_GB;
                cmd.acc_load = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_M3;
            end
            ST_M3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ACC_DMP;
                state_next  = ST_WR;
            end
            ST_WR:
            begin
                unique case (kind_reg)
                    SC_FWD:
                    begin
                        cmd.wr_fn  = 1'b1;
                        kind_next  = SC_BWD;
                        state_next = ST_M1;
                    end
                    SC_BWD:
                    begin
                        cmd.wr_bf  = 1'b1;
                        cmd.step   = 1'b1;
                        j_next     = JW'(j_reg + JW'(1));
                        state_next = ST_P_RD;
                    end
                    SC_LAST:
                    begin
                        // Hold here until the output register can take the sample.
                        if (out_free)
                        begin
                            cmd.wr_fn    = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_R_WR:
            begin
                cmd.rad_wr   = 1'b1;
                cmd.rad_side = status.idx_zero;
                side_next    = status.idx_zero;
                state_next   = ST_R_LAT;
            end
            ST_R_RD:
            begin
                state_next = ST_R_LAT;
            end
            ST_R_LAT:
            begin
                cmd.rad_lat = 1'b1;
                state_next  = ST_R_SQA;
            end
            ST_R_SQA:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_SQ_A;
                state_next  = ST_R_SQB;
            end
            ST_R_SQB:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_SQ_B;
                cmd.sq_lat  = 1'b1;
                state_next  = ST_R_DINIT;
            end
            ST_R_DINIT:
            begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = DCNT_W'(dcnt_reg + DCNT_W'(1));
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_R_KWR;
                end
            end
            ST_R_KWR:
            begin
                cmd.k_wr = 1'b1;
                if (!side_reg && !status.idx_top)
                begin
                    side_next  = 1'b1;
                    state_next = ST_R_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            j_reg     <= '0;
            sweep_reg <= '0;
            init_reg  <= 1'b1;
            kind_reg  <= SC_FWD;
            side_reg  <= 1'b0;
            dcnt_reg  <= '0;
            njcfg_reg <= NJ_RESET;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            sweep_reg <= sweep_next;
            init_reg  <= init_next;
            kind_reg  <= kind_next;
            side_reg  <= side_next;
            dcnt_reg  <= dcnt_next;
            njcfg_reg <= njcfg_next;
        end
    end

    assign sample_busy = (state_reg == ST_P_RD) || (state_reg == ST_P_LAT) ||
                         (state_reg == ST_P_WRX) || (state_reg == ST_M1) ||
                         (state_reg == ST_M2) || (state_reg == ST_ACC) ||
                         (state_reg == ST_M3) || (state_reg == ST_WR);

    `KLT_ASSERT_IMPL(a_j_in_range, sample_busy, (RW'(j_reg) < nj_eff))
    `KLT_ASSERT_IMPL(a_out_load_free, cmd.out_load, out_free)
    `KLT_ASSERT_NEXT(a_busy_after_request, (in_accept && (func != FUNC_NONE)), !in_ready)
    `KLT_ASSERT_IMPL(a_div_count, (state_reg == ST_R_DIV), (dcnt_reg < DCNT_W'(DIV_STEPS)))

endmodule

/* bench/tb_kelly_lochbaum_tube_filter_top.sv */
`timescale 1ns / 1ps

module tb_kelly_lochbaum_tube_filter_top;
    import klt_pkg::*;

    localparam int NJ_MAX = 16;

    typedef struct {
        logic [FUNC_W-1:0]        fn;
        logic signed [SMP_W-1:0]  smp;
        logic signed [GAIN_W-1:0] gain;
        logic signed [GAIN_W-1:0] damp;
        logic [NJ_W-1:0]          idx;
        logic [RAD_W-1:0]         rad;
        bit                       typed;
        logic signed [SMP_W-1:0]  typed_out;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [NJ_W-1:0]          cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic signed [SMP_W-1:0]  sample_in;
    logic signed [GAIN_W-1:0] feedback_gain;
    logic signed [GAIN_W-1:0] damping;
    logic [NJ_W-1:0]          tube_index;
    logic [RAD_W-1:0]         radius;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [SMP_W-1:0]  sample_out;

    // Lattice state mirrored from the block.
    longint      fwd_n[NJ_MAX];
    longint      fwd_f[NJ_MAX];
    longint      bwd_n[NJ_MAX];
    longint      bwd_f[NJ_MAX];
    longint      refl_k[NJ_MAX];
    longint      sect_rad[NJ_MAX+1];
    logic [NJ_W-1:0] nj_reg;

    logic signed [SMP_W-1:0] expected_samples[$];
    int  n_errors;
    int  n_requests;
    int  n_samples_seen;
    bit  long_hold;
    bit  no_idle;
    bit  drained;

    kelly_lochbaum_tube_filter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .sample_in    (sample_in),
        .feedback_gain(feedback_gain),
        .damping      (damping),
        .tube_index   (tube_index),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out)
    );

    always #2 clk = ~clk;

    function automatic longint round_shr(longint a, int s);
        return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
        begin
            return 8388607;
        end
        if (v < -8388608)
        begin
            return -8388608;
        end
        return v;
    endfunction

    function automatic longint junction_term(longint a, longint ga, longint b, longint gb,
                                             longint dmp);
        return clip24(round_shr((a * ga + b * gb) * dmp, 30));
    endfunction

    function automatic int active_nj();
        if (nj_reg < 2)
        begin
            return 2;
        end
        if (nj_reg > NJ_MAX)
        begin
            return NJ_MAX;
        end
        return nj_reg;
    endfunction

    function automatic void recompute_coef(int j);
        longint a2, b2, den, num, q;
        a2 = sect_rad[j] * sect_rad[j];
        b2 = sect_rad[j+1] * sect_rad[j+1];
        den = a2 + b2;
        if (den == 0)
        begin
            refl_k[j] = 0;
            return;
        end
        num = (a2 >= b2) ? a2 - b2 : b2 - a2;
        q = (num * 65536 + den / 2) / den;
        refl_k[j] = (a2 >= b2) ? q : -q;
    endfunction

    function automatic void clear_waves();
        for (int i = 0; i < NJ_MAX; i++)
        begin
            fwd_n[i] = 0;
            fwd_f[i] = 0;
            bwd_n[i] = 0;
            bwd_f[i] = 0;
        end
    endfunction

    // Advances the mirrored lattice by one request; returns 1 when a sample comes out.
    function automatic bit lattice_step(stim_row_t r, output logic signed [SMP_W-1:0] y);
        int     nj;
        int     idx;
        longint k;
        longint prev_fwd[NJ_MAX];
        nj = active_nj();
        y = '0;
        if (r.fn == FUNC_SAMPLE)
        begin
            prev_fwd = fwd_n;
            fwd_n[0] = clip24(round_shr(bwd_n[0] * longint'(r.gain)
                                        + longint'(r.smp) * 16384, 14));
            fwd_f[0] = fwd_n[0];
            k = refl_k[0];
            bwd_f[0] = junction_term(bwd_f[1], 65536 + k, fwd_f[0], k, r.damp);
            for (int j = 1; j + 1 < nj; j++)
            begin
                k = refl_k[j-1];
                bwd_n[j] = bwd_f[j];
                fwd_n[j] = junction_term(fwd_f[j-1], 65536 - k, bwd_n[j], -k, r.damp);
                fwd_f[j] = prev_fwd[j-1];
                k = refl_k[j];
                bwd_f[j] = junction_term(bwd_f[j+1], 65536 + k, fwd_f[j], k, r.damp);
            end
            bwd_n[nj-1] = 0;
            k = refl_k[nj-1];
            fwd_n[nj-1] = junction_term(fwd_f[nj-2], 65536 - k, 0, 0, r.damp);
            y = fwd_n[nj-1][SMP_W-1:0];
            return 1;
        end
        if (r.fn == FUNC_RADIUS)
        begin
            idx = (r.idx > nj) ? nj : r.idx;
            sect_rad[idx] = r.rad;
            if (idx >= 1)
            begin
                recompute_coef(idx - 1);
            end
            if (idx < NJ_MAX)
            begin
                recompute_coef(idx);
            end
        end
        else if (r.fn == FUNC_CLEAR)
        begin
            clear_waves();
        end
        return 0;
    endfunction

    task automatic send_request(stim_row_t r);
        logic signed [SMP_W-1:0] y;
        int gap;
        func          <= r.fn;
        sample_in     <= r.smp;
        feedback_gain <= r.gain;
        damping       <= r.damp;
        tube_index    <= r.idx;
        radius        <= r.rad;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (lattice_step(r, y))
        begin
            expected_samples.push_back(r.typed ? r.typed_out : y);
        end
        n_requests++;
        gap = 0;
        if (!no_idle)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = $urandom_range(10, 40);
                default: gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits for all samples, then lets any radius or clear request finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (250) @(posedge clk);
    endtask

    task automatic write_junctions(logic [NJ_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        nj_reg = v;
        @(posedge clk);
    endtask

    function automatic stim_row_t random_request();
        stim_row_t r;
        int        sel;
        r.typed = 0;
        r.typed_out = '0;
        sel = $urandom_range(0, 99);
        r.fn = (sel < 70) ? FUNC_SAMPLE : (sel < 85) ? FUNC_RADIUS :
               (sel < 93) ? FUNC_CLEAR : FUNC_NONE;
        case ($urandom_range(0, 4))
            0:       r.smp = 24'sh7FFFFF;
            1:       r.smp = 24'sh800000;
            default: r.smp = SMP_W'($urandom());
        endcase
        r.gain = GAIN_W'($urandom());
        case ($urandom_range(0, 5))
            0:       r.damp = 16'sd16384;
            1:       r.damp = 16'sh7FFF;
            2:       r.damp = 16'sh8000;
            default: r.damp = GAIN_W'($urandom_range(12000, 17000));
        endcase
        r.idx = NJ_W'($urandom());
        case ($urandom_range(0, 4))
            0:       r.rad = '0;
            1:       r.rad = 16'hFFFF;
            default: r.rad = RAD_W'($urandom());
        endcase
        return r;
    endfunction

    // Receiver: mostly ready, with short and occasional long stalls.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold = 0;
            end
            else if (no_idle)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:
                    begin
                        out_ready <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    end
                    4:
                    begin
                        out_ready <= 1'b0;
                        repeat ($urandom_range(10, 60)) @(posedge clk);
                    end
                    default:
                    begin
                        out_ready <= 1'b1;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_samples_seen++;
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected sample %0d", sample_out);
                n_errors++;
            end
            else
            begin
                if (sample_out !== expected_samples[0])
                begin
                    $error("sample_out expected %0d got %0d", expected_samples[0], sample_out);
                    n_errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL kelly_lochbaum_tube_filter_top");
        $finish;
    end

    initial
    begin
        stim_row_t directed[$];
        logic [NJ_W-1:0] nj_plan[];

        nj_plan = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd9, 5'd16, 5'd5, 5'd3};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        func = FUNC_SAMPLE;
        sample_in = '0;
        feedback_gain = '0;
        damping = '0;
        tube_index = '0;
        radius = '0;
        n_errors = 0;
        n_requests = 0;
        n_samples_seen = 0;
        long_hold = 0;
        no_idle = 0;
        nj_reg = NJ_RESET;
        clear_waves();
        for (int i = 0; i < NJ_MAX; i++)
        begin
            refl_k[i] = 0;
        end
        for (int i = 0; i <= NJ_MAX; i++)
        begin
            sect_rad[i] = RAD_ONE;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the lattice holds nothing, so the first outputs are zero.
        directed = '{
            '{FUNC_SAMPLE, 24'sh7FFFFF, 16'sh7FFF, 16'sd16384, 5'd0, 16'd0, 1, 24'sd0},
            '{FUNC_SAMPLE, 24'sh800000, 16'sh8000, 16'sh7FFF,  5'd0, 16'd0, 1, 24'sd0},
            '{FUNC_SAMPLE, 24'sd0,      16'sd0,    16'sh8000,  5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sh7FFFFF, 16'sd0,    16'sh7FFF,  5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_RADIUS, 24'sd0,      16'sd0,    16'sd0,     5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_RADIUS, 24'sd0,      16'sd0,    16'sd0,     5'd1, 16'd0, 0, 24'sd0},
            '{FUNC_RADIUS, 24'sd0,      16'sd0,    16'sd0,     5'd31, 16'hFFFF, 0, 24'sd0},
            '{FUNC_RADIUS, 24'sd0,      16'sd0,    16'sd0,     5'd5, 16'hFFFF, 0, 24'sd0},
            '{FUNC_RADIUS, 24'sd0,      16'sd0,    16'sd0,     5'd16, 16'd0, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sh400000, 16'sh7FFF, 16'sd16384, 5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sh800000, 16'sd0,    16'sd16384, 5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_NONE,   24'sh7FFFFF, 16'sd0,    16'sd16384, 5'd3, 16'd7, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sh123456, 16'sd0,    16'sh7FFF,  5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_CLEAR,  24'sd0,      16'sd0,    16'sd0,     5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sd0,      16'sd0,    16'sd16384, 5'd0, 16'd0, 1, 24'sd0},
            '{FUNC_SAMPLE, 24'sh7FFFFF, 16'sd0,    16'sd16384, 5'd0, 16'd0, 0, 24'sd0},
            '{FUNC_SAMPLE, 24'sh7FFFFF, 16'sd0,    16'sd16384, 5'd0, 16'd0, 0, 24'sd0}
        };
        foreach (directed[i])
        begin
            send_request(directed[i]);
        end
        wait_idle();

        foreach (nj_plan[p])
        begin
            write_junctions(nj_plan[p]);
            no_idle = (p == 5);
            if (p == 2)
            begin
                long_hold = 1;
            end
            for (int n = 0; n < 100; n++)
            begin
                send_request(random_request());
            end
            no_idle = 0;
            wait_idle();
        end
        write_junctions(NJ_RESET);
        for (int n = 0; n < 20; n++)
        begin
            send_request(random_request());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);

        $display("Covered %0d requests and %0d output samples over junction counts 0..31,",
                 n_requests, n_samples_seen);
        $display("with radius writes, clears, unused codes and back-pressure stalls.");
        if (n_errors == 0 && expected_samples.size() == 0)
        begin
            $display("PASS kelly_lochbaum_tube_filter_top");
        end
        else
        begin
            $display("FAIL kelly_lochbaum_tube_filter_top");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/klt_pkg.sv
hdl/klt_ram.sv
hdl/klt_dp.sv
hdl/klt_ctrl.sv
hdl/kelly_lochbaum_tube_filter_top.sv
bench/tb_kelly_lochbaum_tube_filter_top.sv
